/* sv/assert_macros.svh */
// assertion macros shared by the blur rtl
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

/* sv/rbb3_pkg.sv */
// types, constants and helper functions of the rgb 3x3 box blur
// no dependencies; compiled first
package rbb3_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int WIDTH_REG_W = 12;
    localparam int HEIGHT_W    = 16;
    localparam int ROW_W       = HEIGHT_W + 1;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int X_W         = SUM_W + 1;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 18;

    localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RESET  = WIDTH_REG_W'(640);
    localparam logic [HEIGHT_W-1:0]    IMAGE_HEIGHT_RESET = HEIGHT_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [PIX_W-1:0] t_pix;
    // one window column: index 0 top row, 1 middle row, 2 bottom row
    typedef logic [2:0][PIX_W-1:0] t_col;
    // per channel values: index 0 red, 1 green, 2 blue
    typedef logic [2:0][SUM_W-1:0] t_sums;
    typedef logic [2:0][CH_W-1:0]  t_rgb;

    // control of one item as it leaves the raster counters
    typedef struct packed {
        logic ignore;
        logic draining;
        logic emit;
        logic last;
        logic mid_rd;
        logic top_rd;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } t_ctl;

    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // ceil(2^18 / (2 * count)); exact quotient for dividends below 2^13
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] m;
        unique case (count)
            CNT_W'(1): m = RECIP_W'(131072);
            CNT_W'(2): m = RECIP_W'(65536);
            CNT_W'(3): m = RECIP_W'(43691);
            CNT_W'(4): m = RECIP_W'(32768);
            CNT_W'(6): m = RECIP_W'(21846);
            CNT_W'(9): m = RECIP_W'(14564);
            default:   m = '0;
        endcase
        return m;
    endfunction

endpackage

/* sv/rbb3_if.sv */
// stream interfaces of the blur: pixel input and blurred result output
// depends on rbb3_pkg
interface rbb3_pix_if;
    import rbb3_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
    logic            is_filler;

    modport source (output valid, in_red, in_green, in_blue, is_filler, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, is_filler, output ready);
endinterface

interface rbb3_res_if;
    import rbb3_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_end;

    modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

/* sv/rgb_box_blur_3x3.sv */
// top level of the streaming rgb 3x3 box blur
// depends on rbb3_pkg, rbb3_if, rbb3_ram, rbb3_scan, rbb3_mean, assert_macros.svh
//
// Streaming 3x3 box blur over 8-bit RGB pixels sent in raster order. Each
// result is the half-up rounded mean of every channel over those 3x3
// neighbours that lie inside the frame (9 inside, 6 on an edge, 4 in a
// corner, fewer for frames one pixel wide or high). Results trail the input
// by one row plus one pixel: after the last pixel of a frame the source sends
// width+1 filler beats to drain the tail, the final result carries frame_end
// and the next frame begins. Filler beats inside a frame are taken and
// dropped; pixel beats while draining act as fillers. Writing either
// register restarts the frame; write only while the block is idle. Width 0
// acts as 1 and widths above MAX_WIDTH clamp to it; height 0 acts as 1.
// The block takes one beat every clock while the result sink keeps up, and a
// result for the beat completing its neighbourhood passes through the stage
// 1, stage 2 and output registers; that rate is set by the two line stores,
// each read once and written once per beat through one read and one write
// port. There is no clearing pass after reset: a line store entry is only read
// for rows already written in the current frame.
module rgb_box_blur_3x3 #(
    parameter int MAX_WIDTH = rbb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [rbb3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rbb3_pkg::CFG_DATA_W-1:0]   i_cfg_wr_data,
    rbb3_pix_if.sink                          i_pix,
    rbb3_res_if.source                        o_res
);
    import rbb3_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = addr_bits(MAX_WIDTH);

    // stage 0: raster counters decide what each beat does
    t_ctl          ctl;
    logic [AW-1:0] col;
    logic          acc, acc_eff, en1, en2, out_free, s1_go;
    t_pix          pix_in;

    // stage 1: line store data back, window shift, neighbourhood sums
    logic          r_s1_valid;
    t_ctl          r_s1_ctl;
    logic [AW-1:0] r_s1_addr;
    t_pix          r_s1_bot;
    t_pix          above_rd, two_rd, mid, top;
    logic          r_fwd_hit;
    t_pix          r_fwd_above, r_fwd_two;
    t_col          r_win_l, r_win_c, new_col;
    t_col          cols [3];
    logic [2:0]    rmask, cmask;
    t_sums         sums;
    logic [1:0]    nrows, ncols;
    logic [CNT_W-1:0] count;

    // stage 2: rounded division
    logic             r_s2_valid;
    t_sums            r_s2_sum;
    logic [CNT_W-1:0] r_s2_count;
    logic             r_s2_last;
    t_rgb             mean;

    // output register
    logic r_out_valid;
    t_rgb r_out_rgb;
    logic r_out_last;

    // each stage moves when the one behind it has room
    assign out_free = !r_out_valid || o_res.ready;
    assign en2      = !r_s2_valid || out_free;
    assign s1_go    = r_s1_valid && en2;
    assign en1      = !r_s1_valid || en2;

    assign i_pix.ready = en1;
    assign acc         = i_pix.valid && en1;
    assign acc_eff     = acc && !ctl.ignore;

    rbb3_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_acc         (acc),
        .i_is_filler   (i_pix.is_filler),
        .o_ctl         (ctl),
        .o_col         (col)
    );

    // draining beats push black pixels; those rows lie below the frame
    assign pix_in = ctl.draining ? '0 : {i_pix.in_red, i_pix.in_green, i_pix.in_blue};

    // row above the current one, and the row above that
    rbb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_above (
        .i_clk     (i_clk),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (r_s1_bot),
        .i_rd_en   (acc_eff),
        .i_rd_addr (col),
        .o_rd_data (above_rd)
    );

    rbb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_two_above (
        .i_clk     (i_clk),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (mid),
        .i_rd_en   (acc_eff),
        .i_rd_addr (col),
        .o_rd_data (two_rd)
    );

    // a read issued in the cycle of a write to the same entry sees old data;
    // one-pixel rows and frame restarts hit this, so bypass the written values
    assign mid = !r_s1_ctl.mid_rd ? '0 : (r_fwd_hit ? r_fwd_above : above_rd);
    assign top = !r_s1_ctl.top_rd ? '0 : (r_fwd_hit ? r_fwd_two : two_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= acc_eff;
            if (acc_eff) begin
                r_fwd_hit <= s1_go && (col == r_s1_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && acc_eff) begin
            r_s1_ctl    <= ctl;
            r_s1_addr   <= col;
            r_s1_bot    <= pix_in;
            r_fwd_above <= r_s1_bot;
            r_fwd_two   <= mid;
        end
    end

    // window: left and centre columns kept, right column is the new beat;
    // for a row-start beat the right column is masked off
    always_comb begin
        new_col[0] = top;
        new_col[1] = mid;
        new_col[2] = r_s1_bot;
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_win_l <= r_win_c;
            r_win_c <= new_col;
        end
    end

    assign cols[0] = r_win_l;
    assign cols[1] = r_win_c;
    assign cols[2] = new_col;
    assign rmask   = {r_s1_ctl.bot_ok, 1'b1, r_s1_ctl.top_ok};
    assign cmask   = {r_s1_ctl.right_ok, 1'b1, r_s1_ctl.left_ok};

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sums[ch] = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (rmask[r] && cmask[c]) begin
                        sums[ch] = sums[ch] + SUM_W'(cols[c][r][(2 - ch) * CH_W +: CH_W]);
                    end
                end
            end
        end
    end

    // samples in the neighbourhood: rows times columns inside the frame
    assign nrows = 2'd1 + 2'(r_s1_ctl.top_ok) + 2'(r_s1_ctl.bot_ok);
    assign ncols = 2'd1 + 2'(r_s1_ctl.left_ok) + 2'(r_s1_ctl.right_ok);
    assign count = CNT_W'(nrows) * CNT_W'(ncols);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= s1_go && r_s1_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && s1_go) begin
            r_s2_sum   <= sums;
            r_s2_count <= count;
            r_s2_last  <= r_s1_ctl.last;
        end
    end

    rbb3_mean u_mean (
        .i_sum   (r_s2_sum),
        .i_count (r_s2_count),
        .o_mean  (mean)
    );

    // output register parts the pipeline from the result sink
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s2_valid) begin
            r_out_rgb  <= mean;
            r_out_last <= r_s2_last;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_red   = r_out_rgb[0];
    assign o_res.out_green = r_out_rgb[1];
    assign o_res.out_blue  = r_out_rgb[2];
    assign o_res.frame_end = r_out_last;

    `ASSERT_AT(a_count_legal, i_clk, i_rst_n,
        (!r_s2_valid || r_s2_count == CNT_W'(1) || r_s2_count == CNT_W'(2) ||
         r_s2_count == CNT_W'(3) || r_s2_count == CNT_W'(4) ||
         r_s2_count == CNT_W'(6) || r_s2_count == CNT_W'(9)),
        "neighbourhood size impossible")
    `ASSERT_AT(a_emit_has_mid, i_clk, i_rst_n,
        ((r_s1_valid && r_s1_ctl.emit) |-> r_s1_ctl.mid_rd),
        "result computed without the row above")
    `ASSERT_AT(a_out_from_s2, i_clk, i_rst_n,
        ($rose(o_res.valid) |-> $past(r_s2_valid)),
        "result beat appeared without a divided item")
endmodule

/* sv/rbb3_ram.sv */
// generic single write port, single read port ram with registered read
// depends on rbb3_pkg for address width helper
module rbb3_ram #(
    parameter int  WIDTH  = rbb3_pkg::PIX_W,
    parameter int  DEPTH  = rbb3_pkg::MAX_WIDTH_DEF,
    localparam int AW     = rbb3_pkg::addr_bits(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

/* sv/rbb3_scan.sv */
// configuration registers and raster counters of the blur
// depends on rbb3_pkg and assert_macros.svh
module rbb3_scan #(
    parameter int  MAX_WIDTH = rbb3_pkg::MAX_WIDTH_DEF,
    localparam int AW        = rbb3_pkg::addr_bits(MAX_WIDTH)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [rbb3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rbb3_pkg::CFG_DATA_W-1:0]   i_cfg_wr_data,
    input  logic                              i_acc,
    input  logic                              i_is_filler,
    output rbb3_pkg::t_ctl                    o_ctl,
    output logic [AW-1:0]                     o_col
);
    import rbb3_pkg::*;
    `include "assert_macros.svh"

    localparam int CW = $clog2(MAX_WIDTH + 1);

    logic [WIDTH_REG_W-1:0] r_image_width;
    logic [HEIGHT_W-1:0]    r_image_height;
    logic [AW-1:0]          r_col, n_col;
    logic [ROW_W-1:0]       r_row, n_row;
    logic [CW-1:0]          w_eff, w_last;
    logic [ROW_W-1:0]       h_row;
    logic                   col0, row_ge1, row_ge2, row_ge3, at_row_end, take;
    t_ctl                   ctl;

    // zero acts as one, oversize width clamps to the line store depth
    always_comb begin
        if (r_image_width == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_image_width);
        end
    end

    assign w_last = w_eff - CW'(1);
    assign h_row  = (r_image_height == '0) ? ROW_W'(1) : ROW_W'(r_image_height);

    assign col0       = (r_col == '0);
    assign row_ge1    = (r_row != '0);
    assign row_ge2    = (r_row >= ROW_W'(2));
    assign row_ge3    = (r_row >= ROW_W'(3));
    assign at_row_end = (CW'(r_col) == w_last);

    always_comb begin
        ctl          = '0;
        ctl.draining = (r_row >= h_row);
        ctl.ignore   = !ctl.draining && i_is_filler;
        ctl.emit     = row_ge2 || (row_ge1 && !col0);
        ctl.mid_rd   = row_ge1;
        ctl.top_rd   = row_ge2;
        if (col0) begin
            // output is the last column of the row two above
            ctl.top_ok   = row_ge3;
            ctl.bot_ok   = (r_row <= h_row);
            ctl.left_ok  = (w_last != '0);
            ctl.right_ok = 1'b0;
            ctl.last     = (r_row == h_row + ROW_W'(1));
        end else begin
            // output is the previous column of the row above
            ctl.top_ok   = row_ge2;
            ctl.bot_ok   = (r_row < h_row);
            ctl.left_ok  = (r_col != AW'(1));
            ctl.right_ok = 1'b1;
            ctl.last     = 1'b0;
        end
    end

    assign take = i_acc && !ctl.ignore;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (take) begin
            if (ctl.emit && ctl.last) begin
                n_col = '0;
                n_row = '0;
            end else if (at_row_end) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RESET;
            r_image_height <= IMAGE_HEIGHT_RESET;
            r_col          <= '0;
            r_row          <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wr_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_wr_data[HEIGHT_W-1:0];
            endcase
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_ctl = ctl;
    assign o_col = r_col;

    `ASSERT_AT(a_col_in_row, i_clk, i_rst_n, (CW'(r_col) < w_eff), "column beyond row width")
    `ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, (take && ctl.emit && ctl.last),
        (r_col == '0 && r_row == '0), "counters not cleared after last output")
endmodule

/* sv/rbb3_mean.sv */
// rounded mean of three channel sums: floor((2*sum + n) / (2*n))
// depends on rbb3_pkg; divides by a reciprocal multiply per channel
module rbb3_mean (
    input  rbb3_pkg::t_sums                 i_sum,
    input  logic [rbb3_pkg::CNT_W-1:0]      i_count,
    output rbb3_pkg::t_rgb                  o_mean
);
    import rbb3_pkg::*;

    logic [RECIP_W-1:0]     m;
    logic [X_W-1:0]         x     [3];
    logic [X_W+RECIP_W-1:0] prod  [3];

    assign m = recip(i_count);

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            x[ch]      = {i_sum[ch], 1'b0} + X_W'(i_count);
            prod[ch]   = (X_W + RECIP_W)'(x[ch]) * (X_W + RECIP_W)'(m);
            o_mean[ch] = prod[ch][RECIP_SHIFT +: CH_W];
        end
    end
endmodule
